// ----- sv/vpa_pkg.sv -----
`timescale 1ns / 1ps
package vpa_pkg;
  localparam int MemUnits = 128;
  localparam int AddrW = 7;
  localparam int SizeW = 8;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatNoFit = 2'd1;
  localparam logic [1:0] StatBad = 2'd2;

  localparam logic [1:0] FitFirst = 2'd0;
  localparam logic [1:0] FitNext = 2'd1;
  localparam logic [1:0] FitBest = 2'd2;
  localparam logic [1:0] FitWorst = 2'd3;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpRelease = 1'b1;

  typedef struct packed {
    logic operation;
    logic [7:0] alloc_units;
    logic [6:0] block_index;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] start_addr;
    logic [7:0] part_size;
    logic [7:0] occupied_count;
  } rsp_t;
endpackage

// ----- sv/vpa_ram.sv -----
`timescale 1ns / 1ps
module vpa_ram #(
  parameter int Width = 15,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/variable_partition_allocator.sv -----
`timescale 1ns / 1ps
// First, best and worst fit allocate by one bitmap scan, then one unit marked per cycle;
// next-fit adds, when an extent fits, a rank modulo by repeated subtraction and then
// a second scan. A release reads its table entry, frees its units and moves the later
// entries down one slot; a rejected request goes straight to the result.
// One request at a time: busy is high until the one-cycle result strobe, which the
// receiver cannot stall. Synchronous reset frees all units, empties the table.
module variable_partition_allocator (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  vpa_pkg::req_t     request,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  output logic              done,
  output vpa_pkg::rsp_t     result
);
  localparam int AW = vpa_pkg::AddrW;
  localparam int SW = vpa_pkg::SizeW;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SCAN  = 10'b0000000010,
    S_MOD   = 10'b0000000100,
    S_MARK  = 10'b0000001000,
    S_RRD   = 10'b0000010000,
    S_RLAT  = 10'b0000100000,
    S_CLR   = 10'b0001000000,
    S_MVRD  = 10'b0010000000,
    S_MVWR  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state;
  logic [1:0] fit_mode;
  logic [vpa_pkg::MemUnits-1:0] occ;
  logic [SW-1:0] total;
  logic [AW-1:0] nf_rank;
  vpa_pkg::req_t req;

  // scan registers
  logic [SW-1:0] pos;          // unit being inspected, reaches MemUnits
  logic          pass2;        // next-fit search pass
  logic          in_run;
  logic [AW-1:0] run_start;
  logic [SW-1:0] run_len;
  logic [AW-1:0] rank;         // extent rank of current run
  logic [SW-1:0] ext_cnt;
  logic          found;
  logic          hit;
  logic [AW-1:0] pick_start;
  logic [SW-1:0] pick_len;
  logic [AW-1:0] pick_rank;
  logic [SW-1:0] base_q;
  logic [SW-1:0] cnt;
  logic [AW-1:0] ptr;
  logic [1:0]    stat;
  logic [AW-1:0] r_addr;
  logic [SW-1:0] r_size;

  // table ram
  logic             t_we;
  logic [AW-1:0]    t_waddr, t_raddr;
  logic [AW+SW-1:0] t_wdata, t_rdata;

  vpa_ram #(.Width(AW + SW), .Depth(vpa_pkg::MemUnits)) u_tab (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  logic          ubit;
  logic          run_end;
  logic [SW-1:0] end_len;
  logic          fits, better;

  assign busy = (state != S_IDLE);
  assign ubit = (pos < SW'(vpa_pkg::MemUnits)) ? occ[pos[AW-1:0]] : 1'b1;
  // a run closes at a used unit or past the end
  assign run_end = in_run && ubit;
  assign end_len = run_len;
  assign fits = end_len >= req.alloc_units;

  always_comb begin
    unique case (fit_mode)
      vpa_pkg::FitBest:  better = !found || end_len < pick_len;
      vpa_pkg::FitWorst: better = !found || end_len > pick_len;
      default:           better = !found;
    endcase
  end

  always_comb begin
    t_we = 1'b0;
    t_waddr = total[AW-1:0];
    t_wdata = {pick_start, req.alloc_units};
    t_raddr = ptr;
    if (state == S_MARK && found && cnt == '0) begin
      t_we = 1'b1;
    end else if (state == S_MVWR) begin
      t_we = 1'b1;
      t_waddr = ptr - AW'(1);
      t_wdata = t_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fit_mode <= vpa_pkg::FitFirst;
      occ <= '0;
      total <= '0;
      nf_rank <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      if (cfg_we) begin
        fit_mode <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req <= request;
            pos <= '0;
            pass2 <= 1'b0;
            in_run <= 1'b0;
            rank <= '0;
            ext_cnt <= '0;
            found <= 1'b0;
            hit <= 1'b0;
            cnt <= '0;
            base_q <= SW'(nf_rank);
            if (request.operation == vpa_pkg::OpRelease) begin
              if (SW'(request.block_index) >= total) begin
                stat <= vpa_pkg::StatBad;
                state <= S_DONE;
              end else begin
                ptr <= request.block_index;
                state <= S_RRD;
              end
            end else if (request.alloc_units == '0 ||
                         request.alloc_units > SW'(vpa_pkg::MemUnits)) begin
              stat <= vpa_pkg::StatBad;
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!ubit) begin
            in_run <= 1'b1;
            run_start <= in_run ? run_start : pos[AW-1:0];
            run_len <= in_run ? run_len + SW'(1) : SW'(1);
          end else begin
            in_run <= 1'b0;
          end
          if (run_end && !pass2) begin
            ext_cnt <= ext_cnt + SW'(1);
          end
          if (run_end && fits) begin
            if (pass2) begin
              // take the first fitting extent at or after the start rank
              if (!hit && SW'(rank) >= base_q) begin
                hit <= 1'b1;
                pick_start <= run_start;
                pick_len <= end_len;
                pick_rank <= rank;
              end
            end else if (better) begin
              found <= 1'b1;
              pick_start <= run_start;
              pick_len <= end_len;
              pick_rank <= rank;
            end
          end
          if (pos == SW'(vpa_pkg::MemUnits)) begin
            pos <= '0;
            rank <= '0;
            state <= (fit_mode == vpa_pkg::FitNext && !pass2) ? S_MOD : S_MARK;
          end else begin
            pos <= pos + SW'(1);
            if (run_end) begin
              rank <= rank + AW'(1);
            end
          end
        end
        S_MOD: begin
          // reduce the next-fit rank modulo the extent count; the lowest
          // fitting extent from pass 1 stands when pass 2 finds none
          if (!found) begin
            state <= S_MARK;
          end else if (base_q >= ext_cnt) begin
            base_q <= base_q - ext_cnt;
          end else begin
            pass2 <= 1'b1;
            state <= S_SCAN;
          end
        end
        S_MARK: begin
          if (!found) begin
            stat <= vpa_pkg::StatNoFit;
            state <= S_DONE;
          end else begin
            if (cnt == '0) begin
              total <= total + SW'(1);
              if (fit_mode == vpa_pkg::FitNext) begin
                if (SW'(pick_rank) + SW'(1) == ext_cnt) begin
                  nf_rank <= '0;
                end else if (pick_len == req.alloc_units) begin
                  nf_rank <= pick_rank;
                end else begin
                  nf_rank <= pick_rank + AW'(1);
                end
              end
            end
            occ[pick_start + cnt[AW-1:0]] <= 1'b1;
            cnt <= cnt + SW'(1);
            if (cnt + SW'(1) == req.alloc_units) begin
              stat <= vpa_pkg::StatOk;
              r_addr <= pick_start;
              r_size <= req.alloc_units;
              state <= S_DONE;
            end
          end
        end
        S_RRD: state <= S_RLAT;
        S_RLAT: begin
          r_addr <= t_rdata[AW+SW-1:SW];
          r_size <= t_rdata[SW-1:0];
          cnt <= '0;
          state <= S_CLR;
        end
        S_CLR: begin
          occ[r_addr + cnt[AW-1:0]] <= 1'b0;
          cnt <= cnt + SW'(1);
          if (cnt + SW'(1) == r_size) begin
            ptr <= ptr + AW'(1);
            state <= (SW'(ptr) + SW'(1) < total) ? S_MVRD : S_DONE;
            if (SW'(ptr) + SW'(1) >= total) begin
              total <= total - SW'(1);
              stat <= vpa_pkg::StatOk;
            end
          end
        end
        S_MVRD: state <= S_MVWR;
        S_MVWR: begin
          ptr <= ptr + AW'(1);
          if (SW'(ptr) + SW'(1) < total) begin
            state <= S_MVRD;
          end else begin
            total <= total - SW'(1);
            stat <= vpa_pkg::StatOk;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          result.status <= stat;
          result.start_addr <= (stat == vpa_pkg::StatOk) ? r_addr : '0;
          result.part_size <= (stat == vpa_pkg::StatOk) ? r_size : '0;
          result.occupied_count <= total;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy || $past(state) == S_DONE)
    else $error("done outside completion");
  assert property (@(posedge clk) disable iff (rst) total <= SW'(vpa_pkg::MemUnits))
    else $error("table overflow");
  assert property (@(posedge clk) disable iff (rst)
    done && result.status != vpa_pkg::StatOk |-> result.part_size == '0)
    else $error("failure carries size");
endmodule

// ----- sim/variable_partition_allocator_test.sv -----
`timescale 1ns / 1ps
module variable_partition_allocator_test;
  logic clk, rst, start, busy, cfg_we, done;
  logic [1:0] cfg_wdata;
  vpa_pkg::req_t request;
  vpa_pkg::rsp_t result;

  variable_partition_allocator uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result)
  );

  // allocator shadow state
  logic [vpa_pkg::MemUnits-1:0] unit_busy;
  int part_base[vpa_pkg::MemUnits];
  int part_len[vpa_pkg::MemUnits];
  int part_count;
  int rover;
  logic [1:0] mode;
  int run_base[vpa_pkg::MemUnits];
  int run_len[vpa_pkg::MemUnits];

  vpa_pkg::rsp_t exp_fifo[8];
  int exp_wr = 0;
  int exp_rd = 0;
  int errors;

  function automatic vpa_pkg::rsp_t mk_rsp(logic [1:0] st, int a, int s);
    vpa_pkg::rsp_t r;
    r.status = st;
    r.start_addr = a[6:0];
    r.part_size = s[7:0];
    r.occupied_count = part_count[7:0];
    return r;
  endfunction

  function automatic vpa_pkg::rsp_t allocate_step(vpa_pkg::req_t q);
    int n, u, i, c, pick, a, s, req, idx;
    bit found;
    n = 0;
    pick = 0;
    found = 0;
    req = q.alloc_units;
    idx = q.block_index;
    if (q.operation == vpa_pkg::OpRelease) begin
      if (idx >= part_count) return mk_rsp(vpa_pkg::StatBad, 0, 0);
      a = part_base[idx];
      s = part_len[idx];
      for (i = 0; i < s && a + i < vpa_pkg::MemUnits; i++) unit_busy[a + i] = 1'b0;
      for (i = idx; i + 1 < part_count; i++) begin
        part_base[i] = part_base[i + 1];
        part_len[i] = part_len[i + 1];
      end
      part_count--;
      return mk_rsp(vpa_pkg::StatOk, a, s);
    end
    if (req == 0 || req > vpa_pkg::MemUnits) return mk_rsp(vpa_pkg::StatBad, 0, 0);
    u = 0;
    while (u < vpa_pkg::MemUnits) begin
      if (unit_busy[u]) begin
        u++;
      end else begin
        run_base[n] = u;
        while (u < vpa_pkg::MemUnits && !unit_busy[u]) u++;
        run_len[n] = u - run_base[n];
        n++;
      end
    end
    if (mode == vpa_pkg::FitNext) begin
      for (c = 0; c < n && !found; c++) begin
        i = (rover % n + c) % n;
        if (run_len[i] >= req) begin
          pick = i;
          found = 1;
        end
      end
    end else begin
      for (i = 0; i < n; i++) begin
        if (run_len[i] >= req && (!found ||
            (mode == vpa_pkg::FitBest && run_len[i] < run_len[pick]) ||
            (mode == vpa_pkg::FitWorst && run_len[i] > run_len[pick]))) begin
          if (!(found && mode == vpa_pkg::FitFirst)) begin
            pick = i;
            found = 1;
          end
        end
      end
    end
    if (!found || part_count >= vpa_pkg::MemUnits) return mk_rsp(vpa_pkg::StatNoFit, 0, 0);
    a = run_base[pick];
    for (i = 0; i < req; i++) unit_busy[a + i] = 1'b1;
    part_base[part_count] = a;
    part_len[part_count] = req;
    part_count++;
    if (mode == vpa_pkg::FitNext) begin
      if (run_len[pick] == req) rover = (n > 1) ? pick % (n - 1) : 0;
      else rover = (pick + 1) % n;
    end
    return mk_rsp(vpa_pkg::StatOk, a, req);
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (exp_wr == exp_rd) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        vpa_pkg::rsp_t e;
        e = exp_fifo[exp_rd % 8];
        exp_rd++;
        if (result.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, result.status);
          errors++;
        end
        if (result.start_addr !== e.start_addr) begin
          $error("start_addr exp %0d got %0d", e.start_addr, result.start_addr);
          errors++;
        end
        if (result.part_size !== e.part_size) begin
          $error("part_size exp %0d got %0d", e.part_size, result.part_size);
          errors++;
        end
        if (result.occupied_count !== e.occupied_count) begin
          $error("occupied_count exp %0d got %0d", e.occupied_count,
                 result.occupied_count);
          errors++;
        end
      end
    end
  end

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("variable_partition_allocator_test failed");
    $finish;
  end

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) g = 0;
    repeat (g) @(posedge clk);
  endtask

  // drive one request; check typed expectation when given
  task automatic send_request(logic op, int sz, int idx, bit typed,
                              vpa_pkg::rsp_t fixed);
    vpa_pkg::rsp_t e;
    vpa_pkg::req_t q;
    request.operation <= op;
    request.alloc_units <= sz[7:0];
    request.block_index <= idx[6:0];
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    q.operation = op;
    q.alloc_units = sz[7:0];
    q.block_index = idx[6:0];
    e = allocate_step(q);
    if (typed && e !== fixed) begin
      $error("table row expectation differs from prediction");
      errors++;
    end
    exp_fifo[exp_wr % 8] = e;
    exp_wr++;
    // hold start low before the next request
    @(posedge clk);
  endtask

  task automatic drain();
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (2 * vpa_pkg::MemUnits + 300) @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode = m;
  endtask

  typedef struct {
    logic op;
    int sz;
    int idx;
    bit typed;
    logic [1:0] st;
    int a;
    int s;
    int cnt;
  } row_t;

  row_t rows[20];

  initial begin
    vpa_pkg::rsp_t f;
    int k, ph, op_roll;
    errors = 0;
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 2'd0;
    request = '0;
    unit_busy = '0;
    part_count = 0;
    rover = 0;
    mode = vpa_pkg::FitFirst;
    rows = '{
      '{vpa_pkg::OpRelease, 0, 0, 1, vpa_pkg::StatBad, 0, 0, 0},
      '{vpa_pkg::OpAlloc, 0, 0, 1, vpa_pkg::StatBad, 0, 0, 0},
      '{vpa_pkg::OpAlloc, 255, 127, 1, vpa_pkg::StatBad, 0, 0, 0},
      '{vpa_pkg::OpAlloc, 129, 0, 1, vpa_pkg::StatBad, 0, 0, 0},
      '{vpa_pkg::OpAlloc, 128, 0, 1, vpa_pkg::StatOk, 0, 128, 1},
      '{vpa_pkg::OpAlloc, 1, 0, 1, vpa_pkg::StatNoFit, 0, 0, 1},
      '{vpa_pkg::OpRelease, 0, 127, 1, vpa_pkg::StatBad, 0, 0, 1},
      '{vpa_pkg::OpRelease, 0, 0, 1, vpa_pkg::StatOk, 0, 128, 0},
      '{vpa_pkg::OpAlloc, 10, 0, 1, vpa_pkg::StatOk, 0, 10, 1},
      '{vpa_pkg::OpAlloc, 5, 0, 1, vpa_pkg::StatOk, 10, 5, 2},
      '{vpa_pkg::OpAlloc, 20, 0, 1, vpa_pkg::StatOk, 15, 20, 3},
      '{vpa_pkg::OpAlloc, 3, 0, 1, vpa_pkg::StatOk, 35, 3, 4},
      '{vpa_pkg::OpRelease, 0, 0, 0, 0, 0, 0, 0},
      '{vpa_pkg::OpRelease, 0, 1, 0, 0, 0, 0, 0},
      '{vpa_pkg::OpAlloc, 4, 0, 0, 0, 0, 0, 0},
      '{vpa_pkg::OpAlloc, 8, 0, 0, 0, 0, 0, 0},
      '{vpa_pkg::OpAlloc, 90, 0, 0, 0, 0, 0, 0},
      '{vpa_pkg::OpAlloc, 1, 0, 0, 0, 0, 0, 0},
      '{vpa_pkg::OpRelease, 0, 2, 0, 0, 0, 0, 0},
      '{vpa_pkg::OpAlloc, 127, 0, 0, 0, 0, 0, 0}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (k = 0; k < 20; k++) begin
      f.status = rows[k].st;
      f.start_addr = rows[k].a[6:0];
      f.part_size = rows[k].s[7:0];
      f.occupied_count = rows[k].cnt[7:0];
      send_request(rows[k].op, rows[k].sz, rows[k].idx, rows[k].typed, f);
      if (k == 11) drain();
      if (k == 14) begin
        drain();
        set_mode(vpa_pkg::FitBest);
      end
      if (k == 16) begin
        drain();
        set_mode(vpa_pkg::FitWorst);
      end
      if (k == 18) begin
        drain();
        set_mode(vpa_pkg::FitNext);
      end
    end
    drain();
    for (ph = 0; ph < 8; ph++) begin
      set_mode(ph[1:0] ^ 2'(ph >> 2));
      for (k = 0; k < 120; k++) begin
        int sz, idx;
        op_roll = $urandom_range(0, 99);
        if (op_roll < 4) sz = $urandom_range(0, 255);
        else if (op_roll < 8) sz = 128;
        else if (op_roll < 80) sz = $urandom_range(1, 12);
        else sz = $urandom_range(1, 40);
        idx = (part_count > 0 && $urandom_range(0, 9) != 0) ?
              $urandom_range(0, part_count - 1) : $urandom_range(0, 127);
        send_request(($urandom_range(0, 99) < 45) ? vpa_pkg::OpRelease : vpa_pkg::OpAlloc,
                     sz, idx, 0, f);
        idle_gap();
      end
      drain();
    end
    if (errors == 0) $display("variable_partition_allocator_test passed");
    else $display("variable_partition_allocator_test failed");
    $finish;
  end
endmodule

// ----- files.f -----
sv/vpa_pkg.sv
sv/vpa_ram.sv
sv/variable_partition_allocator.sv
sim/variable_partition_allocator_test.sv
